@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define DMFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define DMFW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define DMFW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMFW_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/dmfw_pkg.sv @@
// ----------------------------------------------------------------------------
// dmfw_pkg
// Shared constants for the depth map forward warp / hole fill block.
// ----------------------------------------------------------------------------
package dmfw_pkg;

    // default sizing
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 512;
    localparam int DEF_FILL_RADIUS   = 5;
    localparam int DEF_FRACTION_BITS = 4;

    // fixed field widths
    localparam int DEPTH_W      = 8;
    localparam int COORD_W      = 17;
    localparam int KIND_W       = 2;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 10;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 1;

    // register reset values
    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_REG_W'(480);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // source kinds
    localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILLED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

endpackage

@@ rtl/dmfw_store.sv @@
// ----------------------------------------------------------------------------
// dmfw_store
// Depth store and valid map, one write and one registered read per cycle.
// The valid map also takes the clearing sweep.
// ----------------------------------------------------------------------------
module dmfw_store
    import dmfw_pkg::*;
#(
    parameter int AW = $clog2(DEF_MAX_WIDTH) + $clog2(DEF_MAX_HEIGHT)
)
(
    input  logic               clk,
    input  logic [AW-1:0]      rd_addr,
    output logic               rd_valid,
    output logic [DEPTH_W-1:0] rd_depth,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [DEPTH_W-1:0] wr_depth,
    input  logic               clr_en,
    input  logic [AW-1:0]      clr_addr
);

    localparam int DEPTH = 1 << AW;

    logic [DEPTH_W-1:0] depth_mem [DEPTH];
    logic               valid_mem [DEPTH];

    logic [AW-1:0] vm_addr;
    logic          vm_we;
    logic          vm_data;

    // clear sweep has priority on the valid map write port
    always_comb
    begin
        vm_we   = clr_en | wr_en;
        vm_addr = clr_en ? clr_addr : wr_addr;
        vm_data = !clr_en;
    end

    // depth store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            depth_mem[wr_addr] <= wr_depth;
        end
        rd_depth <= depth_mem[rd_addr];
    end

    // valid map
    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            valid_mem[vm_addr] <= vm_data;
        end
        rd_valid <= valid_mem[rd_addr];
    end

endmodule

@@ rtl/dmfw_divider.sv @@
// ----------------------------------------------------------------------------
// dmfw_divider
// Restoring divider, one quotient bit per cycle. Used to turn the raster
// position back into row and column after the frame size changes.
// ----------------------------------------------------------------------------
module dmfw_divider
    import dmfw_pkg::*;
#(
    parameter int DIVIDEND_W = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT),
    parameter int DIVISOR_W  = $clog2(DEF_MAX_WIDTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] work_reg;
    logic [DIVIDEND_W-1:0] work_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  fits;

    // one restoring step
    always_comb
    begin
        rem_sh    = {rem_reg, work_reg[DIVIDEND_W-1]};
        fits      = rem_sh >= {1'b0, div_reg};
        rem_sub   = rem_sh - {1'b0, div_reg};
        rem_next  = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        work_next = {work_reg[DIVIDEND_W-2:0], fits};
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIVIDEND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/dmfw_ring_probe.sv @@
// ----------------------------------------------------------------------------
// dmfw_ring_probe
// Address unit for the hole search: nudges the ring centre away from the
// borders and forms one neighbour of ring k with its in-image flag.
// ----------------------------------------------------------------------------
module dmfw_ring_probe
    import dmfw_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int FILL_RADIUS = DEF_FILL_RADIUS
)
(
    input  logic [$clog2(MAX_HEIGHT)-1:0]     row,
    input  logic [$clog2(MAX_WIDTH)-1:0]      col,
    input  logic [$clog2(FILL_RADIUS+1)-1:0]  k,
    input  logic [2:0]                        n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
    output logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] addr,
    output logic                              inb
);

    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RSW = $clog2(MAX_HEIGHT + 1) + 2;
    localparam int CSW = $clog2(MAX_WIDTH + 1) + 2;

    localparam logic signed [RSW-1:0] ONE_R = RSW'(1);
    localparam logic signed [CSW-1:0] ONE_C = CSW'(1);

    logic signed [RSW-1:0] a, hs, kr, r;
    logic signed [CSW-1:0] b, ws, kc, c;
    logic                  r_up, r_dn, c_up, c_dn;

    // neighbour order: down, up, right, left, then the four diagonals
    always_comb
    begin
        r_up = 1'b0;
        r_dn = 1'b0;
        c_up = 1'b0;
        c_dn = 1'b0;
        unique case (n)
            3'd0: r_up = 1'b1;
            3'd1: r_dn = 1'b1;
            3'd2: c_up = 1'b1;
            3'd3: c_dn = 1'b1;
            3'd4: begin r_up = 1'b1; c_up = 1'b1; end
            3'd5: begin r_up = 1'b1; c_dn = 1'b1; end
            3'd6: begin r_dn = 1'b1; c_dn = 1'b1; end
            3'd7: begin r_dn = 1'b1; c_up = 1'b1; end
        endcase
    end

    // centre adjust near the borders, then offset by k
    always_comb
    begin
        a  = $signed(RSW'(row));
        hs = $signed(RSW'(h_eff));
        kr = $signed(RSW'(k));
        b  = $signed(CSW'(col));
        ws = $signed(CSW'(w_eff));
        kc = $signed(CSW'(k));

        if (a == hs - kr)
        begin
            a = a - ONE_R;
        end
        else if (a == kr - ONE_R)
        begin
            a = a + ONE_R;
        end

        if (b == ws - kc)
        begin
            b = b - ONE_C;
        end
        else if (b == kc - ONE_C)
        begin
            b = b + ONE_C;
        end

        r = r_up ? a + kr : (r_dn ? a - kr : a);
        c = c_up ? b + kc : (c_dn ? b - kc : b);

        inb  = (r >= 0) && (r < hs) && (c >= 0) && (c < ws);
        addr = {r[RW-1:0], c[CW-1:0]};
    end

endmodule

@@ rtl/depth_map_forward_warp_hole_fill_core.sv @@
// ----------------------------------------------------------------------------
// depth_map_forward_warp_hole_fill_core
// Forward-warps depth samples into a frame store, then streams the frame out
// in raster order with ring-search hole filling.
//
//   channel  | handshake            | word
//   ---------+----------------------+-----------------------------------------
//   cfg      | cfg_we               | cfg_index, cfg_data
//   in       | in_valid / in_ready  | command, depth_in, target_x, target_y
//   out      | out_valid / out_ready| depth_out, source_kind, frame_end
//
// A load is accepted, then rounded and written. An emit makes one store
// read per probed place through the single read port, centre first then
// eight places per ring. After a frame size change the first emit also
// runs the bit-serial divider that recomputes row and column.
// After reset and after the last pixel of a frame the valid map is swept,
// one entry a cycle, over all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries
// (524288 at the defaults); in_ready stays low meanwhile.
// A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_map_forward_warp_hole_fill_core
    import dmfw_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FILL_RADIUS   = DEF_FILL_RADIUS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic [DEPTH_W-1:0]        depth_in,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DEPTH_W-1:0]        depth_out,
    output logic [KIND_W-1:0]         source_kind,
    output logic                      frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int KW    = $clog2(FILL_RADIUS + 1);
    localparam int RND_W = COORD_W + 1;

    localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((1 << FRACTION_BITS) - 1);
    localparam logic [COORD_W-1:0] FRAC_HALF = COORD_W'((1 << FRACTION_BITS) >> 1);
    localparam logic [KW-1:0]      K_LAST    = KW'(FILL_RADIUS);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_PROBE = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // round to nearest, ties to even
    function automatic logic signed [RND_W-1:0] round_coord(
        input logic signed [COORD_W-1:0] raw);
        logic signed [COORD_W-1:0] fl;
        logic [COORD_W-1:0]        rem;
        logic                      inc;
        fl  = raw >>> FRACTION_BITS;
        rem = raw & FRAC_MASK;
        inc = (FRACTION_BITS > 0) &&
              ((rem > FRAC_HALF) || ((rem == FRAC_HALF) && fl[0]));
        return $signed({fl[COORD_W-1], fl}) + $signed({{(RND_W-1){1'b0}}, inc});
    endfunction

    logic [2:0]              state_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    dirty_reg;
    logic [TW-1:0]           total_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [RW-1:0]           row_reg;
    logic [CW-1:0]           col_reg;
    logic [AW-1:0]           clr_reg;
    logic [KW-1:0]           k_reg;
    logic [2:0]              n_reg;
    logic                    prev_active_reg;
    logic                    prev_inb_reg;
    logic                    prev_center_reg;
    logic                    prev_last_reg;
    logic [DEPTH_W-1:0]      res_depth_reg;
    logic [KIND_W-1:0]       res_kind_reg;
    logic                    out_valid_reg;
    logic [DEPTH_W-1:0]      depth_out_reg;
    logic [KIND_W-1:0]       kind_out_reg;
    logic                    frame_end_reg;
    logic [DEPTH_W-1:0]      item_depth_reg;
    logic signed [COORD_W-1:0] item_x_reg;
    logic signed [COORD_W-1:0] item_y_reg;

    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic                    in_fire;
    logic                    out_free;
    logic                    last_pix;
    logic signed [RND_W-1:0] rx, ry;
    logic                    load_inb;
    logic [AW-1:0]           load_addr;
    logic [POS_W-1:0]        norm_pos;
    logic                    center;
    logic                    hit;
    logic [AW-1:0]           probe_addr;
    logic                    probe_inb;
    logic [AW-1:0]           rd_addr;
    logic                    rd_valid;
    logic [DEPTH_W-1:0]      rd_depth;
    logic                    div_start;
    logic                    div_done;
    logic [POS_W-1:0]        div_quot;
    logic [WW-1:0]           div_rem;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    // load target
    always_comb
    begin
        rx        = round_coord(item_x_reg);
        ry        = round_coord(item_y_reg);
        load_inb  = (rx >= 0) && (rx < $signed(RND_W'(w_eff))) &&
                    (ry >= 0) && (ry < $signed(RND_W'(h_eff)));
        load_addr = {ry[RW-1:0], rx[CW-1:0]};
    end

    // emit control
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_pix  = (row_reg == RW'(h_eff - HW'(1))) && (col_reg == CW'(w_eff - WW'(1)));
    assign norm_pos  = (TW'(pos_reg) >= total_reg) ? '0 : pos_reg;
    assign div_start = (state_reg == S_MUL);
    assign center    = (k_reg == '0);
    assign hit       = prev_active_reg && prev_inb_reg && rd_valid;
    assign rd_addr   = center ? {row_reg, col_reg} : probe_addr;

    dmfw_ring_probe #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .FILL_RADIUS (FILL_RADIUS)
    ) u_probe (
        .row   (row_reg),
        .col   (col_reg),
        .k     (k_reg),
        .n     (n_reg),
        .w_eff (w_eff),
        .h_eff (h_eff),
        .addr  (probe_addr),
        .inb   (probe_inb)
    );

    dmfw_divider #(
        .DIVIDEND_W (POS_W),
        .DIVISOR_W  (WW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (norm_pos),
        .divisor   (w_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    dmfw_store #(
        .AW (AW)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_depth (rd_depth),
        .wr_en    ((state_reg == S_LOAD) && load_inb),
        .wr_addr  (load_addr),
        .wr_depth (item_depth_reg),
        .clr_en   (state_reg == S_CLEAR),
        .clr_addr (clr_reg)
    );

    // input word capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_depth_reg <= depth_in;
            item_x_reg     <= target_x;
            item_y_reg     <= target_y;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            width_reg       <= RST_IMAGE_WIDTH;
            height_reg      <= RST_IMAGE_HEIGHT;
            dirty_reg       <= 1'b0;
            total_reg       <= '0;
            pos_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            clr_reg         <= '0;
            k_reg           <= '0;
            n_reg           <= '0;
            prev_active_reg <= 1'b0;
            prev_inb_reg    <= 1'b0;
            prev_center_reg <= 1'b0;
            prev_last_reg   <= 1'b0;
            res_depth_reg   <= '0;
            res_kind_reg    <= KIND_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                endcase
                dirty_reg <= 1'b1;
            end

            // frame size, registered from the effective width and height
            total_reg <= TW'(w_eff * h_eff);

            // output word drains
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= (command == CMD_EMIT) ? S_START : S_LOAD;
                end

                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                end

                S_START:
                begin
                    k_reg           <= '0;
                    n_reg           <= '0;
                    prev_active_reg <= 1'b0;
                    prev_last_reg   <= 1'b0;
                    state_reg       <= dirty_reg ? S_MUL : S_PROBE;
                end

                S_MUL:
                begin
                    pos_reg   <= norm_pos;
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        row_reg   <= RW'(div_quot);
                        col_reg   <= CW'(div_rem);
                        dirty_reg <= 1'b0;
                        state_reg <= S_PROBE;
                    end
                end

                S_PROBE:
                begin
                    // judge the previous read, else issue the next place
                    if (hit)
                    begin
                        res_depth_reg <= rd_depth;
                        res_kind_reg  <= prev_center_reg ? KIND_DIRECT : KIND_FILLED;
                        state_reg     <= S_OUT;
                    end
                    else if (prev_last_reg)
                    begin
                        res_depth_reg <= '0;
                        res_kind_reg  <= KIND_NONE;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        prev_active_reg <= 1'b1;
                        prev_inb_reg    <= center ? 1'b1 : probe_inb;
                        prev_center_reg <= center;
                        prev_last_reg   <= (k_reg == K_LAST) && (n_reg == 3'd7);
                        if (center || n_reg == 3'd7)
                        begin
                            k_reg <= k_reg + KW'(1);
                            n_reg <= '0;
                        end
                        else
                        begin
                            n_reg <= n_reg + 3'd1;
                        end
                    end
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (last_pix)
                        begin
                            pos_reg   <= '0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + POS_W'(1);
                            if (col_reg == CW'(w_eff - WW'(1)))
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + RW'(1);
                            end
                            else
                            begin
                                col_reg <= col_reg + CW'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            depth_out_reg <= res_depth_reg;
            kind_out_reg  <= res_kind_reg;
            frame_end_reg <= last_pix;
        end
    end

    assign out_valid   = out_valid_reg;
    assign depth_out   = depth_out_reg;
    assign source_kind = kind_out_reg;
    assign frame_end   = frame_end_reg;

    // checks
    `DMFW_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_done, state_reg == S_DIV)
    `DMFW_ASSERT_NXT(a_last_probe_ends, clk, rst_n, (state_reg == S_PROBE) && prev_last_reg, state_reg == S_OUT)
    `DMFW_ASSERT_NXT(a_frame_end_clears, clk, rst_n, (state_reg == S_OUT) && out_free && last_pix, (state_reg == S_CLEAR) && (clr_reg == '0))
    `DMFW_ASSERT_IMP(a_none_is_zero, clk, rst_n, out_valid_reg && (kind_out_reg == KIND_NONE), depth_out_reg == '0)

endmodule
